FILE: rtl/core/dda_line_rasterizer_unit_macros.svh
// Assertion macros shared by the line rasterizer RTL.
`ifndef DDA_LINE_RASTERIZER_UNIT_MACROS_SVH
`define DDA_LINE_RASTERIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DLR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dda line rasterizer: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define DLR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dda line rasterizer: next-cycle check failed");

`endif

FILE: rtl/core/dda_lr_pkg.sv
// Shared types, codes and defaults for the DDA line rasterizer.
package dda_lr_pkg;

    localparam int DDA_LR_COORD_INT_BITS  = 12;
    localparam int DDA_LR_COORD_FRAC_BITS = 8;
    localparam int DDA_LR_STEP_FRAC_BITS  = 16;

    localparam logic [31:0] DDA_LR_COLOR_RESET = 32'hFF00_00FF;

    // item kinds carried on tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_SPAN  = 6'b000010,
        ST_ABS   = 6'b000100,
        ST_MAX   = 6'b001000,
        ST_DIV_X = 6'b010000,
        ST_DIV_Y = 6'b100000
    } dda_lr_state_t;

    typedef struct packed {
        logic load;   // arm a new line from the setup results
        logic step;   // step item accepted
    } dda_lr_walk_ctrl_t;

    typedef struct packed {
        logic line_active;
        logic out_free;   // output register empty or draining this cycle
    } dda_lr_walk_stat_t;

endpackage

FILE: rtl/core/dda_lr_div.sv
// Shared restoring divider: rounded |span| / steps, one quotient bit per cycle.
module dda_lr_div
    import dda_lr_pkg::*;
#(
    parameter int IN_W = DDA_LR_COORD_INT_BITS + DDA_LR_COORD_FRAC_BITS,
    parameter int SF   = DDA_LR_STEP_FRAC_BITS
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [IN_W:0] span_abs,
    input  logic [IN_W:0] steps,
    output logic          done,
    output logic [SF:0]   quotient
);

    localparam int NW = IN_W + SF + 3;
    localparam int DW = IN_W + 2;
    localparam int QW = SF + 1;
    localparam int CW = $clog2(QW);

    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] low_reg;
    logic [QW-1:0] q_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic          zero_reg;

    logic [NW-1:0] num;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    // numerator = (|span| << (SF+1)) + steps; divisor = 2 * steps
    assign num   = {{(NW-IN_W-1-QW){1'b0}}, span_abs, {QW{1'b0}}}
                 + {{(NW-IN_W-1){1'b0}}, steps};
    assign trial = {rem_reg, low_reg[QW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CW'(QW - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                if (cnt_reg == CW'(QW - 1)) begin
                    busy_reg <= 1'b0;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= num[NW-1:QW];
            low_reg  <= num[QW-1:0];
            den_reg  <= {steps, 1'b0};
            zero_reg <= (steps == '0);
            q_reg    <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
            low_reg <= {low_reg[QW-2:0], 1'b0};
            q_reg   <= {q_reg[QW-2:0], ge};
        end
    end

    assign done     = done_reg;
    // zero-length line: both increments are zero
    assign quotient = zero_reg ? '0 : q_reg;

endmodule

FILE: rtl/core/dda_lr_walker.sv
// Point walker: position accumulators, pixel counter, rounding and output register.
module dda_lr_walker
    import dda_lr_pkg::*;
#(
    parameter int CI = DDA_LR_COORD_INT_BITS,
    parameter int CF = DDA_LR_COORD_FRAC_BITS,
    parameter int SF = DDA_LR_STEP_FRAC_BITS
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  dda_lr_walk_ctrl_t         ctrl,
    input  logic signed [CI+CF-1:0]   start_x,
    input  logic signed [CI+CF-1:0]   start_y,
    input  logic [SF:0]               q_x,
    input  logic [SF:0]               q_y,
    input  logic                      neg_x,
    input  logic                      neg_y,
    input  logic [CI+CF:0]            steps,
    input  logic [31:0]               color,
    input  logic                      out_ready,
    output dda_lr_walk_stat_t         stat,
    output logic                      out_valid,
    output logic [CI-1:0]             pixel_x,
    output logic [CI-1:0]             pixel_y,
    output logic [31:0]               pixel_color,
    output logic                      last_pixel
);

    localparam int IN_W = CI + CF;
    localparam int W    = CI + SF + 1;
    localparam int IW   = SF + 2;

    localparam logic [W-1:0]  RND_UP  = {{(W-SF){1'b0}}, 1'b1, {(SF-1){1'b0}}};
    localparam logic [W-1:0]  RND_DN  = RND_UP - {{(W-1){1'b0}}, 1'b1};
    localparam logic [CI-1:0] PIX_MAX = {1'b0, {(CI-1){1'b1}}};
    localparam logic [CI-1:0] PIX_MIN = {1'b1, {(CI-1){1'b0}}};

    logic signed [W-1:0]  pos_x_reg, pos_y_reg;
    logic signed [IW-1:0] inc_x_reg, inc_y_reg;
    logic [CI:0]          left_reg;
    logic                 active_reg;
    logic                 valid_reg;
    logic [CI-1:0]        px_reg, py_reg;
    logic [31:0]          color_reg;
    logic                 last_reg;

    logic signed [W-1:0]  init_x, init_y;
    logic signed [IW-1:0] inc_x_new, inc_y_new;
    logic [CI-1:0]        rnd_x, rnd_y;
    logic                 is_last;
    logic                 emit;

    // start point into step fraction units
    if (SF >= CF) begin : g_scale_up
        logic signed [W-1:0] sx_ext, sy_ext;
        assign sx_ext = {{(W-IN_W){start_x[IN_W-1]}}, start_x};
        assign sy_ext = {{(W-IN_W){start_y[IN_W-1]}}, start_y};
        assign init_x = sx_ext <<< (SF - CF);
        assign init_y = sy_ext <<< (SF - CF);
    end else begin : g_scale_down
        // magnitude shift, so truncation is toward zero
        logic [IN_W-1:0] mx, my, shx, shy;
        assign mx     = start_x[IN_W-1] ? IN_W'(-start_x) : IN_W'(start_x);
        assign my     = start_y[IN_W-1] ? IN_W'(-start_y) : IN_W'(start_y);
        assign shx    = mx >> (CF - SF);
        assign shy    = my >> (CF - SF);
        assign init_x = start_x[IN_W-1] ? -$signed(shx[W-1:0]) : $signed(shx[W-1:0]);
        assign init_y = start_y[IN_W-1] ? -$signed(shy[W-1:0]) : $signed(shy[W-1:0]);
    end

    assign inc_x_new = neg_x ? -$signed({1'b0, q_x}) : $signed({1'b0, q_x});
    assign inc_y_new = neg_y ? -$signed({1'b0, q_y}) : $signed({1'b0, q_y});

    // half away from zero: negative values round with half minus one, then floor
    function automatic logic [CI-1:0] round_sat(input logic signed [W-1:0] p);
        logic [W-1:0] sum;
        logic [CI:0]  r;
        sum = p[W-1] ? (p + RND_DN) : (p + RND_UP);
        r   = sum[W-1:SF];
        if (r[CI] != r[CI-1]) begin
            round_sat = r[CI] ? PIX_MIN : PIX_MAX;
        end else begin
            round_sat = r[CI-1:0];
        end
    endfunction

    assign rnd_x   = round_sat(pos_x_reg);
    assign rnd_y   = round_sat(pos_y_reg);
    assign is_last = (left_reg <= {{CI{1'b0}}, 1'b1});
    assign emit    = ctrl.step && active_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            left_reg   <= '0;
            valid_reg  <= 1'b0;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            inc_x_reg  <= '0;
            inc_y_reg  <= '0;
        end else begin
            if (ctrl.load) begin
                pos_x_reg  <= init_x;
                pos_y_reg  <= init_y;
                inc_x_reg  <= inc_x_new;
                inc_y_reg  <= inc_y_new;
                left_reg   <= steps[IN_W:CF] + 1'b1;
                active_reg <= 1'b1;
            end else if (emit) begin
                pos_x_reg <= pos_x_reg + {{(W-IW){inc_x_reg[IW-1]}}, inc_x_reg};
                pos_y_reg <= pos_y_reg + {{(W-IW){inc_y_reg[IW-1]}}, inc_y_reg};
                if (is_last) begin
                    left_reg   <= '0;
                    active_reg <= 1'b0;
                end else begin
                    left_reg <= left_reg - 1'b1;
                end
            end
            if (emit) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            px_reg    <= rnd_x;
            py_reg    <= rnd_y;
            color_reg <= color;
            last_reg  <= is_last;
        end
    end

    assign stat.line_active = active_reg;
    assign stat.out_free    = !valid_reg || out_ready;
    assign out_valid        = valid_reg;
    assign pixel_x          = px_reg;
    assign pixel_y          = py_reg;
    assign pixel_color      = color_reg;
    assign last_pixel       = last_reg;

endmodule

FILE: rtl/core/dda_line_rasterizer_unit.sv
// Top level of the DDA line rasterizer: stream ports, setup sequencer, config register.
// Load item: setup states SPAN, ABS and MAX, then the x and y divisions through the
// shared divider, before s_tready rises again.
// Step item: one per cycle while the output register is free; the pixel appears in the output register the next cycle.
// The divide loop (one shared compare-subtract, one quotient bit a cycle) sets load time.
// aresetn is synchronous, active low: idle, no line armed, color = 0xFF0000FF.
module dda_line_rasterizer_unit
    import dda_lr_pkg::*;
#(
    parameter int COORD_INT_BITS  = DDA_LR_COORD_INT_BITS,
    parameter int COORD_FRAC_BITS = DDA_LR_COORD_FRAC_BITS,
    parameter int STEP_FRAC_BITS  = DDA_LR_STEP_FRAC_BITS
) (
    input  logic aclk,
    input  logic aresetn,

    // configuration: pixel color
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,

    // input items
    input  logic s_tvalid,
    output logic s_tready,
    // start_x, start_y, end_x, end_y (signed fixed point), zero padded to bytes
    input  logic [((4*(COORD_INT_BITS+COORD_FRAC_BITS)+7)/8)*8-1:0] s_tdata,
    // op: 0 load line, 1 next pixel
    input  logic [0:0] s_tuser,

    // result items
    output logic m_tvalid,
    input  logic m_tready,
    // pixel_x, pixel_y (signed), color (32 bit), zero padded to bytes
    output logic [((2*COORD_INT_BITS+32+7)/8)*8-1:0] m_tdata,
    // last_pixel
    output logic m_tlast
);

    localparam int CI   = COORD_INT_BITS;
    localparam int CF   = COORD_FRAC_BITS;
    localparam int SF   = STEP_FRAC_BITS;
    localparam int IN_W = CI + CF;
    localparam int M_W  = ((2*CI+32+7)/8)*8;

    `include "dda_line_rasterizer_unit_macros.svh"

    dda_lr_state_t state_reg, state_next;

    logic [31:0] color_reg;

    // captured endpoints
    logic signed [IN_W-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    // spans, magnitudes, signs and step count
    logic signed [IN_W:0] dx_reg, dy_reg;
    logic [IN_W:0]        ax_reg, ay_reg, steps_reg;
    logic                 neg_x_reg, neg_y_reg;
    logic [SF:0]          qx_reg;
    logic                 div_go_reg;

    logic              s_acc;
    logic              div_done;
    logic [SF:0]       div_q;
    logic [IN_W:0]     div_a;
    dda_lr_walk_ctrl_t walk_ctrl;
    dda_lr_walk_stat_t walk_stat;
    logic [CI-1:0]     px, py;
    logic [31:0]       pcolor;

    // Not ready while a line is being set up, nor while an unclaimed pixel waits.
    assign s_tready = (state_reg == ST_IDLE) && walk_stat.out_free;
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            color_reg <= DDA_LR_COLOR_RESET;
        end else if (cfg_we) begin
            color_reg <= cfg_wdata;
        end
    end

    // Setup sequencer: spans, magnitudes, max, then x and y through the divider.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_acc && (s_tuser[0] == OP_LOAD)) begin
                    state_next = ST_SPAN;
                end
            end
            ST_SPAN:  state_next = ST_ABS;
            ST_ABS:   state_next = ST_MAX;
            ST_MAX:   state_next = ST_DIV_X;
            ST_DIV_X: begin
                if (div_done) begin
                    state_next = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                if (div_done) begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            div_go_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            // one start pulse as each division begins
            div_go_reg <= (state_reg == ST_MAX) || ((state_reg == ST_DIV_X) && div_done);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc && (s_tuser[0] == OP_LOAD)) begin
            sx_reg <= s_tdata[IN_W-1:0];
            sy_reg <= s_tdata[2*IN_W-1:IN_W];
            ex_reg <= s_tdata[3*IN_W-1:2*IN_W];
            ey_reg <= s_tdata[4*IN_W-1:3*IN_W];
        end
        if (state_reg == ST_SPAN) begin
            dx_reg <= {ex_reg[IN_W-1], ex_reg} - {sx_reg[IN_W-1], sx_reg};
            dy_reg <= {ey_reg[IN_W-1], ey_reg} - {sy_reg[IN_W-1], sy_reg};
        end
        if (state_reg == ST_ABS) begin
            ax_reg    <= dx_reg[IN_W] ? (IN_W+1)'(-dx_reg) : (IN_W+1)'(dx_reg);
            ay_reg    <= dy_reg[IN_W] ? (IN_W+1)'(-dy_reg) : (IN_W+1)'(dy_reg);
            neg_x_reg <= dx_reg[IN_W];
            neg_y_reg <= dy_reg[IN_W];
        end
        if (state_reg == ST_MAX) begin
            steps_reg <= (ax_reg > ay_reg) ? ax_reg : ay_reg;
        end
        if ((state_reg == ST_DIV_X) && div_done) begin
            qx_reg <= div_q;
        end
    end

    assign div_a = (state_reg == ST_DIV_Y) ? ay_reg : ax_reg;

    dda_lr_div #(
        .IN_W (IN_W),
        .SF   (SF)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_go_reg),
        .span_abs (div_a),
        .steps    (steps_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // The y quotient goes straight into the walker on the cycle it finishes.
    assign walk_ctrl.load = (state_reg == ST_DIV_Y) && div_done;
    assign walk_ctrl.step = s_acc && (s_tuser[0] == OP_STEP);

    dda_lr_walker #(
        .CI (CI),
        .CF (CF),
        .SF (SF)
    ) u_walker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (walk_ctrl),
        .start_x     (sx_reg),
        .start_y     (sy_reg),
        .q_x         (qx_reg),
        .q_y         (div_q),
        .neg_x       (neg_x_reg),
        .neg_y       (neg_y_reg),
        .steps       (steps_reg),
        .color       (color_reg),
        .out_ready   (m_tready),
        .stat        (walk_stat),
        .out_valid   (m_tvalid),
        .pixel_x     (px),
        .pixel_y     (py),
        .pixel_color (pcolor),
        .last_pixel  (m_tlast)
    );

    assign m_tdata = M_W'({pcolor, py, px});

    // No item taken while the sequencer is busy.
    `DLR_ASSERT_NOW(a_busy_not_ready, aclk, aresetn, state_reg != ST_IDLE, !s_tready)
    // A load item starts setup on the next cycle.
    `DLR_ASSERT_NEXT(a_load_starts_setup, aclk, aresetn, s_acc && (s_tuser[0] == OP_LOAD), state_reg == ST_SPAN)
    // Finishing the second division arms a line.
    `DLR_ASSERT_NEXT(a_setup_arms_line, aclk, aresetn, walk_ctrl.load, walk_stat.line_active)
    // A step gives a pixel exactly when a line was armed.
    `DLR_ASSERT_NEXT(a_step_emits_if_active, aclk, aresetn, walk_ctrl.step, m_tvalid == $past(walk_stat.line_active))
    // The divider only reports completion inside a divide state.
    `DLR_ASSERT_NOW(a_div_done_in_div, aclk, aresetn, div_done, (state_reg == ST_DIV_X) || (state_reg == ST_DIV_Y))

endmodule
